>>> hw/rtl/mcpm_pkg.sv
// shared types and constants of the multichannel pcm mixer
package mcpm_pkg;

   // field widths of the stream transactions
   localparam int CMD_W       = 3;
   localparam int CHAN_W      = 4;
   localparam int ADDR_W      = 14;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 17;
   localparam int VOL_W       = 7;
   localparam int SAMPLE_W    = 16;
   localparam int STATUS_W    = 2;
   localparam int MASK_W      = 16;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 2 * SAMPLE_W - STATUS_W - MASK_W;

   // decoded operation queue depth
   localparam int QUEUE_DEPTH = 2;

   // sample scaling: ((byte - 128) << 8) * gain / 127
   localparam logic [BYTE_W-1:0] SILENCE = 8'd128;
   localparam int MAG_W       = 8;
   localparam int PROD_W      = MAG_W + VOL_W;
   localparam int RECIP_W     = 24;
   // ceil(2^30 / 127): x*256/127 == (x * RECIP) >> 22 for every x below 2^15
   localparam logic [RECIP_W-1:0] RECIP = 24'd8454661;
   localparam int RECIP_SHIFT = 22;
   localparam int SCALED_W    = PROD_W + RECIP_W;
   localparam int QUOT_W      = 17;

   // command codes on the request side
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 3'd0,
      CMD_START  = 3'd1,
      CMD_STOP   = 3'd2,
      CMD_VOLUME = 3'd3,
      CMD_MIX    = 3'd4
   } cmd_type;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   // operation kinds after classification
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_STOP,
      OP_VOLUME,
      OP_MIX
   } op_kind_type;

   // one classified transaction travelling from front to back
   typedef struct packed {
      op_kind_type           kind;
      logic [CHAN_W-1:0]     channel;
      logic [ADDR_W-1:0]     address;
      logic [BYTE_W-1:0]     sample_byte;
      logic [LEN_W-1:0]      length;
      logic [VOL_W-1:0]      volume;
      logic [STATUS_W-1:0]   status;
   } op_type;

endpackage

>>> hw/rtl/mcpm_front.sv
// request decoder: unpacks and classifies each transaction into an operation
module mcpm_front #(
   parameter int CHANNELS     = 16,
   parameter int SAMPLE_DEPTH = 16384
) (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // channel, address, sample_byte, length, volume, zero pad
   input  logic [mcpm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command
   input  logic [mcpm_pkg::CMD_W-1:0]         req_tuser,
   input  logic                               queue_full,
   output logic                               queue_push,
   output mcpm_pkg::op_type                   queue_op
);

   logic [mcpm_pkg::CHAN_W-1:0] chan;
   logic [mcpm_pkg::ADDR_W-1:0] addr;
   logic [mcpm_pkg::BYTE_W-1:0] sbyte;
   logic [mcpm_pkg::LEN_W-1:0]  len;
   logic [mcpm_pkg::VOL_W-1:0]  vol;
   logic                        chan_ok;
   logic                        addr_ok;

   // field unpacking
   assign chan  = req_tdata[3:0];
   assign addr  = req_tdata[17:4];
   assign sbyte = req_tdata[25:18];
   assign len   = req_tdata[42:26];
   assign vol   = req_tdata[49:43];

   assign chan_ok = 32'(chan) < 32'(CHANNELS);
   assign addr_ok = 32'(addr) < 32'(SAMPLE_DEPTH);

   // handshake into the queue
   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;

   // classification and status
   always_comb begin
      queue_op.kind        = mcpm_pkg::OP_NONE;
      queue_op.channel     = chan;
      queue_op.address     = addr;
      queue_op.sample_byte = sbyte;
      queue_op.length      = len;
      queue_op.volume      = vol;
      queue_op.status      = mcpm_pkg::STATUS_OK;
      case (mcpm_pkg::cmd_type'(req_tuser))
         mcpm_pkg::CMD_LOAD: begin
            if (chan_ok && addr_ok) queue_op.kind = mcpm_pkg::OP_LOAD;
         end
         mcpm_pkg::CMD_START: begin
            if (chan_ok) begin
               if (len == '0) begin
                  queue_op.status = mcpm_pkg::STATUS_ZERO_LEN;
               end else if (32'(len) > 32'(SAMPLE_DEPTH)) begin
                  queue_op.status = mcpm_pkg::STATUS_TOO_LONG;
               end else begin
                  queue_op.kind = mcpm_pkg::OP_START;
               end
            end
         end
         mcpm_pkg::CMD_STOP: begin
            if (chan_ok) queue_op.kind = mcpm_pkg::OP_STOP;
         end
         mcpm_pkg::CMD_VOLUME: begin
            if (chan_ok) queue_op.kind = mcpm_pkg::OP_VOLUME;
         end
         mcpm_pkg::CMD_MIX: begin
            queue_op.kind = mcpm_pkg::OP_MIX;
         end
         default: begin
            queue_op.kind = mcpm_pkg::OP_NONE;
         end
      endcase
   end

endmodule

>>> hw/rtl/mcpm_queue.sv
// short fifo of classified operations between decoder and executor
module mcpm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcpm_pkg::op_type  push_op,
   output logic              full,
   input  logic              pop,
   output mcpm_pkg::op_type  pop_op,
   output logic              empty
);

   localparam int PTR_W = (mcpm_pkg::QUEUE_DEPTH > 1) ? $clog2(mcpm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mcpm_pkg::QUEUE_DEPTH + 1);

   mcpm_pkg::op_type entry_ff [mcpm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full   = count_ff == CNT_W'(mcpm_pkg::QUEUE_DEPTH);
   assign empty  = count_ff == '0;
   assign pop_op = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(mcpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(mcpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_op;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(mcpm_pkg::QUEUE_DEPTH))
      else $error("queue fill count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule

>>> hw/rtl/mcpm_back.sv
// executor: channel state, sample memory, mixing sequencer and result register
module mcpm_back #(
   parameter int CHANNELS     = 16,
   parameter int SAMPLE_DEPTH = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               queue_empty,
   input  mcpm_pkg::op_type                   queue_op,
   output logic                               queue_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // left_sample, right_sample, status, active_mask, zero pad
   output logic [mcpm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W  = $clog2(SAMPLE_DEPTH + 1);
   localparam int STORE  = CHANNELS * SAMPLE_DEPTH;
   localparam int MEM_AW = $clog2(STORE);
   localparam int PW     = (CHANNELS > 16) ? CHANNELS : 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic [CH_W-1:0]     issue_ff, issue_in;
   logic [CHANNELS-1:0] playing_ff, playing_in;
   logic [POS_W-1:0]    pos_ff  [CHANNELS];
   logic [POS_W-1:0]    pos_in  [CHANNELS];
   logic [POS_W-1:0]    len_ff  [CHANNELS];
   logic [POS_W-1:0]    len_in  [CHANNELS];
   logic [mcpm_pkg::VOL_W-1:0] gain_ff [CHANNELS];
   logic [mcpm_pkg::VOL_W-1:0] gain_in [CHANNELS];

   logic [mcpm_pkg::BYTE_W-1:0] sample_mem_ff [STORE];
   logic [mcpm_pkg::BYTE_W-1:0] rdata_ff;
   logic                        mem_we, mem_re;
   logic [MEM_AW-1:0]           mem_waddr, mem_raddr;

   // mixing pipeline
   logic                          s1_valid_ff, s1_valid_in;
   logic [mcpm_pkg::VOL_W-1:0]    s1_gain_ff, s1_gain_in;
   logic                          s2_valid_ff;
   logic                          s2_neg_ff;
   logic [mcpm_pkg::PROD_W-1:0]   s2_prod_ff;
   logic                          s3_valid_ff;
   logic                          s3_neg_ff;
   logic [mcpm_pkg::SCALED_W-1:0] s3_scaled_ff;
   logic [mcpm_pkg::SAMPLE_W-1:0] sum_ff, sum_in;

   logic                          neg_in;
   logic [mcpm_pkg::MAG_W-1:0]    mag_in;
   logic [mcpm_pkg::QUOT_W-1:0]   quot;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mcpm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                          out_free, busy, emit, last_chan;
   logic [mcpm_pkg::SAMPLE_W-1:0] emit_sample;
   logic [mcpm_pkg::STATUS_W-1:0] emit_status;
   logic [PW-1:0]                 play_ext;
   logic [mcpm_pkg::MASK_W-1:0]   mask;
   logic [CH_W-1:0]               op_idx;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign busy      = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign last_chan = issue_ff == CH_W'(CHANNELS - 1);
   assign op_idx    = CH_W'(queue_op.channel);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mem_waddr = MEM_AW'(32'(queue_op.channel) * 32'(SAMPLE_DEPTH)
                              + 32'(queue_op.address));
   assign mem_raddr = MEM_AW'(32'(issue_ff) * 32'(SAMPLE_DEPTH) + 32'(pos_ff[issue_ff]));

   // operation execution and channel sequencing
   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      playing_in  = playing_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      gain_in     = gain_ff;
      queue_pop   = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      s1_valid_in = 1'b0;
      s1_gain_in  = s1_gain_ff;
      emit        = 1'b0;
      emit_sample = '0;
      emit_status = mcpm_pkg::STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty && out_free) begin
               queue_pop   = 1'b1;
               emit        = 1'b1;
               emit_status = queue_op.status;
               case (queue_op.kind)
                  mcpm_pkg::OP_LOAD: begin
                     mem_we = 1'b1;
                  end
                  mcpm_pkg::OP_START: begin
                     playing_in[op_idx] = 1'b1;
                     pos_in[op_idx]     = '0;
                     len_in[op_idx]     = POS_W'(queue_op.length);
                     gain_in[op_idx]    = queue_op.volume;
                  end
                  mcpm_pkg::OP_STOP: begin
                     playing_in[op_idx] = 1'b0;
                  end
                  mcpm_pkg::OP_VOLUME: begin
                     gain_in[op_idx] = queue_op.volume;
                  end
                  mcpm_pkg::OP_MIX: begin
                     emit     = 1'b0;
                     state_in = ST_ISSUE;
                     issue_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            // one channel per cycle: retire finished ones, fetch a sample otherwise
            if (playing_ff[issue_ff]) begin
               if (pos_ff[issue_ff] >= len_ff[issue_ff]) begin
                  playing_in[issue_ff] = 1'b0;
               end else begin
                  mem_re            = 1'b1;
                  s1_valid_in       = 1'b1;
                  s1_gain_in        = gain_ff[issue_ff];
                  pos_in[issue_ff]  = pos_ff[issue_ff] + 1'b1;
               end
            end
            if (last_chan) begin
               state_in = ST_DRAIN;
            end else begin
               issue_in = issue_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!busy && out_free) begin
               emit        = 1'b1;
               emit_sample = sum_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // scaling stages: magnitude times gain, then times the reciprocal of 127
   assign neg_in = rdata_ff < mcpm_pkg::SILENCE;
   assign mag_in = neg_in ? (mcpm_pkg::SILENCE - rdata_ff) : (rdata_ff - mcpm_pkg::SILENCE);
   assign quot   = s3_scaled_ff[mcpm_pkg::RECIP_SHIFT +: mcpm_pkg::QUOT_W];

   // wrapping accumulation
   always_comb begin
      sum_in = sum_ff;
      if (state_ff == ST_IDLE && queue_pop && queue_op.kind == mcpm_pkg::OP_MIX) begin
         sum_in = '0;
      end else if (s3_valid_ff) begin
         sum_in = s3_neg_ff ? sum_ff - quot[mcpm_pkg::SAMPLE_W-1:0]
                            : sum_ff + quot[mcpm_pkg::SAMPLE_W-1:0];
      end
   end

   // result register
   assign play_ext = PW'(playing_in);
   assign mask     = play_ext[mcpm_pkg::MASK_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{mcpm_pkg::RSP_PAD_W{1'b0}}, mask, emit_status,
                         emit_sample, emit_sample};
      end
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         playing_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         playing_ff   <= playing_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // channel parameters and pipeline payload
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      len_ff       <= len_in;
      gain_ff      <= gain_in;
      s1_gain_ff   <= s1_gain_in;
      s2_neg_ff    <= neg_in;
      s2_prod_ff   <= mcpm_pkg::PROD_W'(mag_in) * mcpm_pkg::PROD_W'(s1_gain_ff);
      s3_neg_ff    <= s2_neg_ff;
      s3_scaled_ff <= mcpm_pkg::SCALED_W'(s2_prod_ff) * mcpm_pkg::SCALED_W'(mcpm_pkg::RECIP);
      sum_ff       <= sum_in;
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (mem_we) sample_mem_ff[mem_waddr] <= queue_op.sample_byte;
      if (mem_re) rdata_ff <= sample_mem_ff[mem_raddr];
   end

`ifndef ASSERT_OFF
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !busy)
      else $error("mixing pipeline busy while idle");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE && playing_ff[issue_ff] |->
         pos_ff[issue_ff] <= len_ff[issue_ff])
      else $error("play position beyond length");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      queue_pop && queue_op.kind == mcpm_pkg::OP_STOP |=>
         !playing_ff[$past(op_idx)])
      else $error("stopped channel still playing");
`endif

endmodule

>>> hw/rtl/multichannel_pcm_mixer.sv
// multichannel pcm mixer top level: decoder, operation queue and executor
//
// usage: each request transaction carries a command in req_tuser and its
// operands in req_tdata; every request yields exactly one response
// transaction on rsp_* carrying the mixed sample (left and right equal,
// zero for non-mix commands), a status code and the mask of playing channels.
// loads, starts, stops and volume changes finish when the executor pops them,
// so their response is registered in the cycle after that, and one such
// command can be retired per cycle while the response register is free.
// a mix command walks the channels one per cycle through the sample memory
// read port, then drains the scaling pipeline (s1, s2, s3) into the
// accumulator before its response is registered, and a new mix starts
// only after the previous one has retired.
// a two entry queue sits between decoder and executor, so requests are
// still taken while a response waits; when rsp_tready stays low the response
// register holds and the queue fills, then req_tready drops.
// reset clears the playing flags (nothing playing) but not the positions,
// lengths or gains; sample memory content is undefined until loaded and needs no clearing.
module multichannel_pcm_mixer #(
   parameter int CHANNELS     = 16,
   parameter int SAMPLE_DEPTH = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // channel[3:0], address[17:4], sample_byte[25:18], length[42:26],
   // volume[49:43], zero pad[55:50]
   input  logic [mcpm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command[2:0]
   input  logic [mcpm_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // left_sample[15:0], right_sample[31:16], status[33:32],
   // active_mask[49:34], zero pad[55:50]
   output logic [mcpm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic             queue_push, queue_full, queue_pop, queue_empty;
   mcpm_pkg::op_type push_op, pop_op;

   // request decoding
   mcpm_front #(
      .CHANNELS     (CHANNELS),
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_op   (push_op)
   );

   // decoupling queue
   mcpm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (queue_push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (queue_pop),
      .pop_op  (pop_op),
      .empty   (queue_empty)
   );

   // execution and response
   mcpm_back #(
      .CHANNELS     (CHANNELS),
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_op    (pop_op),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> tb/sv/tb_multichannel_pcm_mixer.sv
// self-checking stream testbench of the multichannel pcm mixer
module tb_multichannel_pcm_mixer;

   localparam int CHANNELS     = 16;
   localparam int SAMPLE_DEPTH = 16384;
   localparam int STORE_SIZE   = CHANNELS * SAMPLE_DEPTH;
   localparam int RANDOM_ITEMS = 500;

   // command codes that the block decodes as no operation
   localparam logic [mcpm_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [mcpm_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   // pressure windows, in cycles after time zero
   localparam int STALL_START = 1200;
   localparam int STALL_LEN   = 400;
   localparam int CALM_FIRST  = 2500;
   localparam int CALM_LAST   = 4000;
   localparam int IDLE_PCT    = 27;

   typedef struct {
      logic [mcpm_pkg::CMD_W-1:0]  command;
      logic [mcpm_pkg::CHAN_W-1:0] channel;
      logic [mcpm_pkg::ADDR_W-1:0] address;
      logic [mcpm_pkg::BYTE_W-1:0] sample_byte;
      logic [mcpm_pkg::LEN_W-1:0]  length;
      logic [mcpm_pkg::VOL_W-1:0]  volume;
      bit                          wait_drain;
   } mixer_cmd_type;

   typedef struct {
      logic [mcpm_pkg::SAMPLE_W-1:0] left;
      logic [mcpm_pkg::SAMPLE_W-1:0] right;
      logic [mcpm_pkg::STATUS_W-1:0] status;
      logic [mcpm_pkg::MASK_W-1:0]   mask;
   } mixer_rsp_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [mcpm_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [mcpm_pkg::CMD_W-1:0]       req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mcpm_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   int cycle_count = 0;
   int mismatch_count = 0;
   int stall_left = 0;

   mixer_cmd_type pending_cmds[$];
   mixer_rsp_type expected_rsps[$];

   // predicted channel state, updated on every accepted request
   bit          ch_playing [CHANNELS];
   int          ch_pos     [CHANNELS];
   int          ch_len     [CHANNELS];
   int          ch_gain    [CHANNELS];
   logic [7:0]  sample_mem [STORE_SIZE];

   // stimulus-side view of playback, so that no unwritten entry is ever mixed
   bit          plan_playing [CHANNELS];
   int          plan_pos     [CHANNELS];
   int          plan_len     [CHANNELS];
   bit          plan_written [STORE_SIZE];
   bit          drain_next = 1'b0;
   bit          drain_done = 1'b0;
   int          issued = 0;

   multichannel_pcm_mixer #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_DEPTH(SAMPLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic bit calm_window();
      return cycle_count >= CALM_FIRST && cycle_count <= CALM_LAST;
   endfunction

   // mixer behavior: state update and response for one accepted command
   function automatic mixer_rsp_type apply_command(mixer_cmd_type c);
      mixer_rsp_type r;
      logic [mcpm_pkg::SAMPLE_W-1:0] sum;
      int ch;
      int centered;
      int term;
      int idx;
      sum = '0;
      r.status = mcpm_pkg::STATUS_OK;
      ch = int'(c.channel);
      case (c.command)
         mcpm_pkg::CMD_LOAD: begin
            sample_mem[{c.channel, c.address}] = c.sample_byte;
         end
         mcpm_pkg::CMD_START: begin
            if (c.length == 0) begin
               r.status = mcpm_pkg::STATUS_ZERO_LEN;
            end else if (int'(c.length) > SAMPLE_DEPTH) begin
               r.status = mcpm_pkg::STATUS_TOO_LONG;
            end else begin
               ch_playing[ch] = 1'b1;
               ch_pos[ch] = 0;
               ch_len[ch] = int'(c.length);
               ch_gain[ch] = int'(c.volume);
            end
         end
         mcpm_pkg::CMD_STOP: ch_playing[ch] = 1'b0;
         mcpm_pkg::CMD_VOLUME: ch_gain[ch] = int'(c.volume);
         mcpm_pkg::CMD_MIX: begin
            for (int k = 0; k < CHANNELS; k++) begin
               if (ch_playing[k]) begin
                  if (ch_pos[k] >= ch_len[k]) begin
                     // played out: cleared instead of contributing
                     ch_playing[k] = 1'b0;
                  end else begin
                     idx = k * SAMPLE_DEPTH + ch_pos[k];
                     centered = int'(sample_mem[idx]) - 128;
                     term = (centered * 256 * ch_gain[k]) / 127;
                     sum = sum + term[15:0];
                     ch_pos[k] = ch_pos[k] + 1;
                  end
               end
            end
         end
         default: ;
      endcase
      r.left = sum;
      r.right = sum;
      r.mask = '0;
      for (int k = 0; k < CHANNELS && k < mcpm_pkg::MASK_W; k++) r.mask[k] = ch_playing[k];
      return r;
   endfunction

   function automatic mixer_cmd_type random_cmd();
      mixer_cmd_type c;
      c.command = mcpm_pkg::CMD_W'($urandom_range(CMD_SPARE_LAST));
      c.channel = mcpm_pkg::CHAN_W'($urandom_range(CHANNELS - 1));
      c.address = mcpm_pkg::ADDR_W'($urandom_range(SAMPLE_DEPTH - 1));
      c.sample_byte = mcpm_pkg::BYTE_W'($urandom_range(255));
      c.length = mcpm_pkg::LEN_W'($urandom_range(2 ** mcpm_pkg::LEN_W - 1));
      c.volume = mcpm_pkg::VOL_W'($urandom_range(127));
      c.wait_drain = 1'b0;
      return c;
   endfunction

   // queue one command; a negative operand is left random
   task automatic issue(input logic [mcpm_pkg::CMD_W-1:0] command, input int ch,
                        input int addr, input int sbyte, input int len, input int vol);
      mixer_cmd_type item;
      mixer_cmd_type fill;
      int slot;
      item = random_cmd();
      item.command = command;
      if (ch >= 0) item.channel = mcpm_pkg::CHAN_W'(ch);
      if (addr >= 0) item.address = mcpm_pkg::ADDR_W'(addr);
      if (sbyte >= 0) item.sample_byte = mcpm_pkg::BYTE_W'(sbyte);
      if (len >= 0) item.length = mcpm_pkg::LEN_W'(len);
      if (vol >= 0) item.volume = mcpm_pkg::VOL_W'(vol);
      case (command)
         mcpm_pkg::CMD_LOAD: plan_written[{item.channel, item.address}] = 1'b1;
         mcpm_pkg::CMD_START: begin
            if (item.length != 0 && int'(item.length) <= SAMPLE_DEPTH) begin
               plan_playing[item.channel] = 1'b1;
               plan_pos[item.channel] = 0;
               plan_len[item.channel] = int'(item.length);
            end
         end
         mcpm_pkg::CMD_STOP: plan_playing[item.channel] = 1'b0;
         mcpm_pkg::CMD_MIX: begin
            // load every sample this frame will read that is not yet written
            for (int k = 0; k < CHANNELS; k++) begin
               if (plan_playing[k]) begin
                  if (plan_pos[k] >= plan_len[k]) begin
                     plan_playing[k] = 1'b0;
                  end else begin
                     slot = k * SAMPLE_DEPTH + plan_pos[k];
                     if (!plan_written[slot]) begin
                        fill = random_cmd();
                        fill.command = mcpm_pkg::CMD_LOAD;
                        fill.channel = mcpm_pkg::CHAN_W'(k);
                        fill.address = mcpm_pkg::ADDR_W'(plan_pos[k]);
                        pending_cmds.push_back(fill);
                        plan_written[slot] = 1'b1;
                        issued++;
                     end
                     plan_pos[k] = plan_pos[k] + 1;
                  end
               end
            end
         end
         default: ;
      endcase
      item.wait_drain = drain_next;
      drain_next = 1'b0;
      pending_cmds.push_back(item);
      issued++;
   endtask

   // request driver: holds a transaction until taken, idles at random otherwise
   always @(posedge clock) begin : drive_req
      bit offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_command(pending_cmds.pop_front()));
         end
         if (!(req_tvalid && !req_tready)) begin
            offer = pending_cmds.size() != 0
                    && (calm_window() || $urandom_range(99) >= IDLE_PCT);
            if (offer && pending_cmds[0].wait_drain && expected_rsps.size() != 0) offer = 1'b0;
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= {{(mcpm_pkg::REQ_TDATA_W - 50){1'b0}}, pending_cmds[0].volume,
                             pending_cmds[0].length, pending_cmds[0].sample_byte,
                             pending_cmds[0].address, pending_cmds[0].channel};
               req_tuser <= pending_cmds[0].command;
            end
         end
      end
   end

   // one long back-pressure stretch so the request side fills up
   always @(posedge clock) begin : hold_off
      if (reset) begin
         stall_left <= 0;
      end else if (cycle_count == STALL_START) begin
         stall_left <= STALL_LEN;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // response monitor: checks each transaction against the oldest prediction
   always @(posedge clock) begin : watch_rsp
      mixer_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with none pending: tdata=%h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata[15:0] !== want.left) begin
                  $error("left_sample expected %0d actual %0d",
                         $signed(want.left), $signed(rsp_tdata[15:0]));
                  mismatch_count++;
               end
               if (rsp_tdata[31:16] !== want.right) begin
                  $error("right_sample expected %0d actual %0d",
                         $signed(want.right), $signed(rsp_tdata[31:16]));
                  mismatch_count++;
               end
               if (rsp_tdata[33:32] !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_tdata[33:32]);
                  mismatch_count++;
               end
               if (rsp_tdata[49:34] !== want.mask) begin
                  $error("active_mask expected %h actual %h", want.mask, rsp_tdata[49:34]);
                  mismatch_count++;
               end
               if (rsp_tdata[mcpm_pkg::RSP_TDATA_W-1:50] !== '0) begin
                  $error("pad expected 0 actual %h", rsp_tdata[mcpm_pkg::RSP_TDATA_W-1:50]);
                  mismatch_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm_window() || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   // stimulus, then drain and verdict
   initial begin
      int pick;
      int len;
      int vol;
      // rejected starts and an empty frame
      issue(mcpm_pkg::CMD_START, 3, -1, -1, 0, -1);
      issue(mcpm_pkg::CMD_START, 4, -1, -1, SAMPLE_DEPTH + 1, -1);
      issue(mcpm_pkg::CMD_START, 5, -1, -1, 65536, -1);
      issue(mcpm_pkg::CMD_MIX, -1, -1, -1, -1, -1);
      // six full-scale channels make the sum wrap
      for (int k = 0; k < 6; k++) issue(mcpm_pkg::CMD_LOAD, k, 0, 255, -1, -1);
      for (int k = 0; k < 6; k++) issue(mcpm_pkg::CMD_START, k, -1, -1, 1, 127);
      // most negative term on a full-depth channel
      issue(mcpm_pkg::CMD_LOAD, 6, 0, 0, -1, -1);
      issue(mcpm_pkg::CMD_START, 6, -1, -1, SAMPLE_DEPTH, 127);
      // truncation toward zero of a small negative term
      issue(mcpm_pkg::CMD_LOAD, 7, 0, 127, -1, -1);
      issue(mcpm_pkg::CMD_START, 7, -1, -1, 2, 1);
      issue(mcpm_pkg::CMD_MIX, -1, -1, -1, -1, -1);
      // played-out channels get cleared on this frame
      issue(mcpm_pkg::CMD_MIX, -1, -1, -1, -1, -1);
      issue(mcpm_pkg::CMD_VOLUME, 6, -1, -1, -1, 0);
      issue(CMD_SPARE_LAST, -1, -1, -1, -1, -1);
      issue(CMD_SPARE_FIRST, -1, -1, -1, -1, -1);
      issue(mcpm_pkg::CMD_STOP, 6, -1, -1, -1, -1);
      // restart while still playing
      issue(mcpm_pkg::CMD_START, 7, -1, -1, 3, 127);
      issue(mcpm_pkg::CMD_MIX, -1, -1, -1, -1, -1);

      // random traffic, mostly load/start/mix scenes with noise in unused fields
      while (issued < RANDOM_ITEMS) begin
         // once, halfway: the sender waits until every response is back
         if (!drain_done && issued >= RANDOM_ITEMS / 2) begin
            drain_next = 1'b1;
            drain_done = 1'b1;
         end
         pick = int'($urandom_range(99));
         vol = ($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? 127 : 0) : -1;
         if (pick < 25) begin
            issue(mcpm_pkg::CMD_LOAD, -1,
                  ($urandom_range(9) < 6) ? int'($urandom_range(31)) : -1,
                  ($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? 255 : 0) : -1,
                  -1, -1);
         end else if (pick < 37) begin
            case ($urandom_range(19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: len = int'($urandom_range(1, 24));
               13: len = SAMPLE_DEPTH;
               14: len = SAMPLE_DEPTH - 1;
               15: len = int'($urandom_range(1, SAMPLE_DEPTH));
               16: len = 0;
               17: len = SAMPLE_DEPTH + 1;
               18: len = 65536;
               default: len = int'($urandom_range(SAMPLE_DEPTH + 1, 2 ** mcpm_pkg::LEN_W - 1));
            endcase
            issue(mcpm_pkg::CMD_START, -1, -1, -1, len, vol);
         end else if (pick < 43) begin
            issue(mcpm_pkg::CMD_STOP, -1, -1, -1, -1, -1);
         end else if (pick < 51) begin
            issue(mcpm_pkg::CMD_VOLUME, -1, -1, -1, -1, vol);
         end else if (pick < 54) begin
            issue(mcpm_pkg::CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                  -1, -1, -1, -1, -1);
         end else begin
            repeat ($urandom_range(1, 6)) issue(mcpm_pkg::CMD_MIX, -1, -1, -1, -1, -1);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4 * CHANNELS) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
